@@ rtl/cfb_pkg.sv @@
// Shared types, constants and the CRC-8 byte update for the CRC-8 CR/LF frame builder.
// No dependencies; imported by every module of the block.
package cfb_pkg;

	localparam logic [7:0] CRC_POLY = 8'h85;
	localparam logic [7:0] CHAR_CR  = 8'd13;
	localparam logic [7:0] CHAR_LF  = 8'd10;

	// Trailer sequencer, one-hot
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CHK  = 4'b0010,
		ST_CR   = 4'b0100,
		ST_LF   = 4'b1000
	} cfb_state_t;

	// Input transfer event, from framer to remainder logic
	typedef struct packed {
		logic accept;
		logic last;
	} cfb_xfer_t;

	// Non-augmented division: shift each message bit in at bit 0, MSB first
	function automatic logic [7:0] crc8_absorb(input logic [7:0] rem, input logic [7:0] msg);
		logic [7:0] r;
		logic       top;
		r = rem;
		for (int k = 7; k >= 0; k--) begin
			top = r[7];
			r   = {r[6:0], msg[k]};
			if (top) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

endpackage

@@ rtl/cfb_crc.sv @@
// Remainder register and start-value register of the frame builder.
// Depends on cfb_pkg for the byte update function and the transfer struct.
module cfb_crc import cfb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [7:0] cfg_wdata,
	input  cfb_xfer_t xfer,
	input  logic [7:0] data_byte,
	output logic [7:0] check_byte
);

	logic [7:0] crc_start_q;
	logic [7:0] remainder_q;

	assign check_byte = crc8_absorb(remainder_q, data_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_start_q <= '0;
			remainder_q <= '0;
		end else if (cfg_we) begin
			// restart the running check from the new start value
			crc_start_q <= cfg_wdata;
			remainder_q <= cfg_wdata;
		end else if (xfer.accept) begin
			remainder_q <= xfer.last ? crc_start_q : check_byte;
		end
	end

endmodule

@@ rtl/cfb_framer.sv @@
// Output register and trailer sequencer (check byte, CR, LF) of the frame builder.
// Depends on cfb_pkg for the state type, character constants and transfer struct.
module cfb_framer import cfb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic [7:0] check_byte,
	output cfb_xfer_t  xfer,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_eof
);

	cfb_state_t state_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_eof_q;
	logic [7:0] chk_q;
	logic       load;

	// output register is free when empty or being drained this cycle
	assign load     = !out_valid_q || out_ready;
	assign in_ready = load && (state_q == ST_IDLE);

	assign xfer.accept = in_valid && in_ready;
	assign xfer.last   = in_last;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_eof   = out_eof_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else if (load) begin
			unique case (state_q)
				ST_IDLE: begin
					out_valid_q <= in_valid;
					if (in_valid && in_last) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_CR;
				end
				ST_CR: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_LF;
				end
				ST_LF: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					out_valid_q <= 1'b0;
					state_q     <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (xfer.accept) begin
			chk_q <= check_byte;
		end
		if (load) begin
			unique case (state_q)
				ST_IDLE: begin
					out_byte_q <= in_byte;
					out_eof_q  <= 1'b0;
				end
				ST_CHK: begin
					out_byte_q <= chk_q;
					out_eof_q  <= 1'b0;
				end
				ST_CR: begin
					out_byte_q <= CHAR_CR;
					out_eof_q  <= 1'b0;
				end
				ST_LF: begin
					out_byte_q <= CHAR_LF;
					out_eof_q  <= 1'b1;
				end
				default: begin
					out_byte_q <= in_byte;
					out_eof_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule

@@ rtl/crc8_crlf_frame_builder_unit.sv @@
// Top level of the CRC-8 CR/LF frame builder: stream ports, remainder logic, framer.
// Depends on cfb_pkg, cfb_crc and cfb_framer.
//
// Payload bytes enter on the s_axis stream and leave unchanged on m_axis through
// the output register, one transfer per cycle while m_axis_tready is high and no trailer is being sent.
// Each byte is folded into an 8-bit remainder (polynomial 0x85, MSB first,
// non-augmented, no zero flush). On the byte marked with s_axis_tlast the block
// appends the remainder, CR and LF, asserts m_axis_tlast on the LF and reloads
// the remainder from crc_start. After a last byte the trailer sequencer holds
// s_axis_tready low while it emits the three trailer bytes through the
// single output register. Write crc_start with cfg_we/cfg_wdata while the stream
// is idle; the write also reloads the running remainder at once. Frames always
// hold at least one byte.
module crc8_crlf_frame_builder_unit import cfb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// configuration: crc_start
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	// payload in
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tlast,   // last_byte
	// framed bytes out
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tlast    // end_of_frame
);

	cfb_xfer_t  xfer;
	logic [7:0] check_byte;

	// Running remainder; check_byte is the remainder after the current byte
	cfb_crc u_crc (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.xfer       (xfer),
		.data_byte  (s_axis_tdata),
		.check_byte (check_byte)
	);

	// Output register and trailer burst
	cfb_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.check_byte (check_byte),
		.xfer       (xfer),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (m_axis_tdata),
		.out_eof    (m_axis_tlast)
	);

endmodule

@@ verif/crc8_frame_checker.sv @@
// Checker for the CRC-8 CR/LF frame builder: watches the crc_start writes and both streams,
// predicts every framed output byte and compares it with what the block sends.
// Depends on cfb_pkg for the polynomial and the CR/LF codes.
module crc8_frame_checker import cfb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       s_axis_tvalid,
	input  logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tlast,   // last_byte
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  logic [7:0] m_axis_tdata,   // [7:0] out_byte
	input  logic       m_axis_tlast,   // end_of_frame
	output int         fail_count,
	output int         pending
);

	typedef struct packed {
		logic [7:0] value;
		logic       eof;
	} framed_byte_t;

	framed_byte_t framed_q[$];
	logic [7:0]   start_value;
	logic [7:0]   running_crc;

	// Fold one message byte into the remainder, MSB first, no zero flush
	function automatic logic [7:0] fold_crc8(input logic [7:0] rem, input logic [7:0] msg);
		logic [7:0] r;
		logic [7:0] m;
		logic       carry;
		r = rem;
		m = msg;
		repeat (8) begin
			carry = r[7];
			r     = (r << 1) | {7'd0, m[7]};
			m     = m << 1;
			if (carry) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	task automatic report(input string what, input int want, input int got);
		$display("mismatch at %0t: %s expected 0x%02h got 0x%02h", $realtime, what, want, got);
		fail_count++;
	endtask

	always @(posedge clk) begin
		framed_byte_t got;
		framed_byte_t want;
		if (!arst_n) begin
			start_value = 8'd0;
			running_crc = 8'd0;
			framed_q.delete();
		end else begin
			if (cfg_we) begin
				start_value = cfg_wdata;
				running_crc = cfg_wdata;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				running_crc = fold_crc8(running_crc, s_axis_tdata);
				framed_q.push_back('{value: s_axis_tdata, eof: 1'b0});
				if (s_axis_tlast) begin
					framed_q.push_back('{value: running_crc, eof: 1'b0});
					framed_q.push_back('{value: CHAR_CR, eof: 1'b0});
					framed_q.push_back('{value: CHAR_LF, eof: 1'b1});
					running_crc = start_value;
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{value: m_axis_tdata, eof: m_axis_tlast};
				if (framed_q.size() == 0) begin
					report("unexpected output byte", 0, int'(got.value));
				end else begin
					want = framed_q.pop_front();
					if (got.value !== want.value) begin
						report("out_byte", int'(want.value), int'(got.value));
					end
					if (got.eof !== want.eof) begin
						report("end_of_frame", int'(want.eof), int'(got.eof));
					end
				end
			end
		end
		pending = framed_q.size();
	end

endmodule

@@ verif/tb_crc8_crlf_frame_builder_unit.sv @@
// Testbench top for the CRC-8 CR/LF frame builder: clock, reset, crc_start writes,
// payload stimulus and output back-pressure; the verdict comes from crc8_frame_checker.
// Depends on cfb_pkg, crc8_crlf_frame_builder_unit and crc8_frame_checker.
module tb_crc8_crlf_frame_builder_unit;
	import cfb_pkg::*;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int PHASE_ITEMS   = 150;
	localparam int STALL_CYCLES  = 400;
	localparam int DRAIN_CYCLES  = 20;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;   // [7:0] data_byte
	logic       s_axis_tlast;   // last_byte
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;   // [7:0] out_byte
	logic       m_axis_tlast;   // end_of_frame

	int fail_count;
	int pending;
	int src_idle_pct;
	int sink_idle_pct;
	int stall_req;
	int stall_seen;
	int stall_left;
	int cycle_count;

	crc8_crlf_frame_builder_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	crc8_frame_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// Free-running clock, period 12
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: count rising edges and give up once the limit is passed
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	// Output side: drive tready on the falling edge. A new hold-off request
	// starts a stretch that takes priority and is counted down here, one
	// cycle per falling edge.
	initial begin
		m_axis_tready = 1'b0;
		stall_left    = 0;
		stall_seen    = 0;
		forever begin
			@(negedge clk);
			if (stall_req != stall_seen) begin
				stall_seen = stall_req;
				stall_left = STALL_CYCLES;
			end
			if (stall_left > 0) begin
				m_axis_tready = 1'b0;
				stall_left--;
			end else begin
				m_axis_tready = ($urandom_range(0, 99) >= sink_idle_pct);
			end
		end
	end

	// Offer one payload byte, idling first at the sender's rate. Hold the byte
	// until its transfer completes, then drop tvalid on the next falling edge;
	// a following call raises it again in the same step with blocking writes.
	task automatic push_byte(input logic [7:0] b, input logic is_last);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = b;
		s_axis_tlast  = is_last;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	// Wait until every predicted byte has left the block
	task automatic wait_drained();
		while (pending != 0) @(negedge clk);
		@(negedge clk);
	endtask

	// Write crc_start for one cycle; this also reloads the running remainder
	task automatic write_start(input logic [7:0] v);
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// Random frames: mostly a few bytes, now and then a single byte. Between
	// frames, occasionally drain and load a fresh start value.
	task automatic run_phase(input logic [7:0] start_v, input logic with_stall);
		int sent;
		int len;
		sent = 0;
		wait_drained();
		write_start(start_v);
		while (sent < PHASE_ITEMS) begin
			len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 10);
			for (int i = 0; i < len; i++) begin
				// Starve the output for a long stretch while the sender keeps going
				if (with_stall && sent == 60) begin
					stall_req++;
				end
				push_byte(8'($urandom_range(0, 255)), i == len - 1);
				sent++;
			end
			if ($urandom_range(0, 7) == 0) begin
				wait_drained();
				write_start(8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = 8'd0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'd0;
		s_axis_tlast  = 1'b0;
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		stall_req     = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed frames from the reset start value: extreme bytes, one-byte frames
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h80, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'hFE, 1'b1);
		push_byte(8'h0D, 1'b0);
		push_byte(8'h0A, 1'b1);

		// Rewrite crc_start in the middle of a frame: the check restarts from it
		push_byte(8'h55, 1'b0);
		push_byte(8'hAA, 1'b0);
		wait_drained();
		write_start(8'hFF);
		push_byte(8'h12, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b1);

		// Back to the lowest start value
		wait_drained();
		write_start(8'h00);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1);
		push_byte(8'h7F, 1'b1);

		// Random phases under changing back-pressure
		src_idle_pct  = 30;
		sink_idle_pct = 50;
		run_phase(8'hFF, 1'b1);
		src_idle_pct  = 50;
		sink_idle_pct = 30;
		run_phase(8'($urandom_range(0, 255)), 1'b0);
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		run_phase(8'h00, 1'b0);

		// Drain, then give stray outputs a chance to show up
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/cfb_pkg.sv
rtl/cfb_crc.sv
rtl/cfb_framer.sv
rtl/crc8_crlf_frame_builder_unit.sv
verif/crc8_frame_checker.sv
verif/tb_crc8_crlf_frame_builder_unit.sv
